FILE: src/sha1_hash_defines.svh
`ifndef SHA1_HASH_DEFINES_SVH
`define SHA1_HASH_DEFINES_SVH

// Checked only while out of reset.
`define SHA1_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SHA1_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/sha1_pkg.sv
package sha1_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [31:0] K_R0 = 32'h5a827999;
  localparam logic [31:0] K_R1 = 32'h6ed9eba1;
  localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_R3 = 32'hca62c1d6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam int ROUNDS = 80;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_BYTE_LAST,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    NEXT_IDLE,
    NEXT_PAD,
    NEXT_LEN,
    NEXT_OUT
  } after_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

endpackage

FILE: src/sha1_front.sv
module sha1_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_data,
  input  logic          in_has_byte,
  input  logic          in_last,
  input  logic          q_full,
  output sha1_pkg::push_t push
);
  import sha1_pkg::*;

  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Classify each beat; an item with neither byte nor end mark is dropped.
  always_comb begin
    push.item.data = in_data;
    push.item.cmd  = CMD_BYTE;
    push.valid     = 1'b0;
    unique case ({in_has_byte, in_last})
      2'b10: begin
        push.item.cmd = CMD_BYTE;
        push.valid    = accept;
      end
      2'b11: begin
        push.item.cmd = CMD_BYTE_LAST;
        push.valid    = accept;
      end
      2'b01: begin
        push.item.cmd = CMD_FINISH;
        push.valid    = accept;
      end
      default: begin
        push.valid = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/sha1_queue.sv
module sha1_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  sha1_pkg::push_t push,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output sha1_pkg::item_t head
);
  import sha1_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == (QPTR_W + 1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

endmodule

FILE: src/sha1_core.sv
module sha1_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  sha1_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     out_digest_word,
  output logic [2:0]      out_word_index,
  output logic            out_last_word
);
  import sha1_pkg::*;

  state_t      state_r, state_nxt;
  after_t      after_r, after_nxt;
  logic [60:0] cnt_r, cnt_nxt;
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] regs_r [5];
  logic [31:0] regs_nxt [5];
  logic [31:0] chain_r [5];
  logic [31:0] chain_nxt [5];
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic [2:0]  out_index_r, out_index_nxt;
  logic        out_last_r, out_last_nxt;

  logic [5:0]  pos;
  logic [3:0]  wsel;
  logic [4:0]  bshift;
  logic [63:0] bits;
  logic [31:0] byte_word, pad_word, keep_mask;
  logic [31:0] f, k, t, sched_new;

  assign pos       = cnt_r[5:0];
  assign wsel      = pos[5:2];
  assign bshift    = {~pos[1:0], 3'b000};
  assign bits      = {cnt_r, 3'b000};
  assign byte_word = {24'b0, q_item.data} << bshift;
  assign pad_word  = {24'b0, PAD_BYTE} << bshift;
  assign keep_mask = ~(32'hffffffff >> {pos[1:0], 3'b000});

  // One round of the compression
  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (regs_r[1] & regs_r[2]) | (~regs_r[1] & regs_r[3]);
      k = K_R0;
    end else if (rnd_r < 7'd40) begin
      f = regs_r[1] ^ regs_r[2] ^ regs_r[3];
      k = K_R1;
    end else if (rnd_r < 7'd60) begin
      f = (regs_r[1] & regs_r[2]) | (regs_r[1] & regs_r[3]) | (regs_r[2] & regs_r[3]);
      k = K_R2;
    end else begin
      f = regs_r[1] ^ regs_r[2] ^ regs_r[3];
      k = K_R3;
    end
    t         = rotl(regs_r[0], 5) + f + regs_r[4] + k + w_r[0];
    sched_new = rotl(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0], 1);
  end

  always_comb begin
    state_nxt     = state_r;
    after_nxt     = after_r;
    cnt_nxt       = cnt_r;
    rnd_nxt       = rnd_r;
    oidx_nxt      = oidx_r;
    w_nxt         = w_r;
    regs_nxt      = regs_r;
    chain_nxt     = chain_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.cmd) inside
            CMD_BYTE, CMD_BYTE_LAST: begin
              for (int i = 0; i < 16; i++) begin
                if (4'(i) == wsel) begin
                  w_nxt[i] = (pos[1:0] == 2'b00) ? byte_word : (w_r[i] | byte_word);
                end
              end
              cnt_nxt = cnt_r + 61'd1;
              if (pos == 6'd63) begin
                state_nxt = ST_ROUND;
                regs_nxt  = chain_r;
                rnd_nxt   = '0;
                after_nxt = (q_item.cmd == CMD_BYTE_LAST) ? NEXT_PAD : NEXT_IDLE;
              end else if (q_item.cmd == CMD_BYTE_LAST) begin
                state_nxt = ST_PAD;
              end
            end
            CMD_FINISH: begin
              state_nxt = ST_PAD;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_PAD: begin
        for (int i = 0; i < 16; i++) begin
          if (4'(i) == wsel) begin
            w_nxt[i] = (w_r[i] & keep_mask) | pad_word;
          end else if (4'(i) > wsel) begin
            w_nxt[i] = '0;
          end
        end
        // No room for the length: it goes into an extra block.
        if (pos[5:3] == 3'b111) begin
          after_nxt = NEXT_LEN;
        end else begin
          w_nxt[14] = bits[63:32];
          w_nxt[15] = bits[31:0];
          after_nxt = NEXT_OUT;
        end
        state_nxt = ST_ROUND;
        regs_nxt  = chain_r;
        rnd_nxt   = '0;
      end

      ST_LEN: begin
        for (int i = 0; i < 14; i++) begin
          w_nxt[i] = '0;
        end
        w_nxt[14] = bits[63:32];
        w_nxt[15] = bits[31:0];
        after_nxt = NEXT_OUT;
        state_nxt = ST_ROUND;
        regs_nxt  = chain_r;
        rnd_nxt   = '0;
      end

      ST_ROUND: begin
        regs_nxt[0] = t;
        regs_nxt[1] = regs_r[0];
        regs_nxt[2] = rotl(regs_r[1], 30);
        regs_nxt[3] = regs_r[2];
        regs_nxt[4] = regs_r[3];
        // Slide the schedule window: w_r[0] always holds this round's word.
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = sched_new;
        rnd_nxt   = rnd_r + 7'd1;
        if (rnd_r == 7'(ROUNDS - 1)) begin
          state_nxt = ST_ADD;
        end
      end

      ST_ADD: begin
        for (int i = 0; i < 5; i++) begin
          chain_nxt[i] = chain_r[i] + regs_r[i];
        end
        unique case (after_r)
          NEXT_IDLE: state_nxt = ST_IDLE;
          NEXT_PAD:  state_nxt = ST_PAD;
          NEXT_LEN:  state_nxt = ST_LEN;
          NEXT_OUT: begin
            state_nxt = ST_OUT;
            oidx_nxt  = '0;
          end
          default:   state_nxt = ST_IDLE;
        endcase
      end

      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = chain_r[oidx_r];
          out_index_nxt = oidx_r;
          out_last_nxt  = (oidx_r == 3'd4);
          oidx_nxt      = oidx_r + 3'd1;
          if (oidx_r == 3'd4) begin
            chain_nxt = H_INIT;
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      after_r     <= NEXT_IDLE;
      cnt_r       <= '0;
      rnd_r       <= '0;
      oidx_r      <= '0;
      chain_r     <= H_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      after_r     <= after_nxt;
      cnt_r       <= cnt_nxt;
      rnd_r       <= rnd_nxt;
      oidx_r      <= oidx_nxt;
      chain_r     <= chain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    regs_r      <= regs_nxt;
    out_word_r  <= out_word_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_index_r;
  assign out_last_word   = out_last_r;

endmodule

FILE: src/sha1_hash.sv
// The back end takes bytes from the item queue one at a time; each full 64-byte block is
// compressed (80 rounds on one round unit, then the chaining add) before more are taken.
// The end of a message adds a pad step, the compression of one or two blocks, and
// five result beats, one per cycle when the output is not stalled.
// Reset (synchronous, rst_n low) empties the item queue, drops any pending beat
// and loads the initial chaining values with a zero byte count.
`include "sha1_hash_defines.svh"

module sha1_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha1_pkg::*;

  push_t push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  item_t q_item;

  sha1_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .in_has_byte (in_has_byte),
    .in_last     (in_last),
    .q_full      (q_full),
    .push        (push)
  );

  sha1_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_item)
  );

  sha1_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  `SHA1_ASSERT(a_index_range, out_valid |-> out_word_index <= 3'd4, "digest index out of range")
  `SHA1_ASSERT(a_last_on_h4, out_valid |-> (out_last_word == (out_word_index == 3'd4)), "last flag mismatch")
  `SHA1_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result pending after reset")

endmodule

FILE: sim/digest_check_pkg.sv
package digest_check_pkg;

  localparam int          WORDS_OUT = 5;
  localparam int          LAST_IDX  = WORDS_OUT - 1;
  localparam int          BLOCK_LEN = 64;
  localparam int          ROUND_CNT = 80;
  localparam logic [7:0]  PAD_MARK  = 8'h80;

  localparam logic [31:0] IV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };
  localparam logic [31:0] RC [4] = '{
    32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        final_word;
  } digest_beat_t;

  class digest_scoreboard;
    logic [31:0]  chain [5];
    logic [31:0]  blk [16];
    logic [60:0]  msg_bytes;
    digest_beat_t digest_q [$];
    int           mismatches;

    function new();
      mismatches = 0;
      foreach (blk[i]) blk[i] = '0;
      restart();
    endfunction

    function void restart();
      foreach (chain[i]) chain[i] = IV[i];
      msg_bytes = '0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void absorb_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, t;
      int r;
      foreach (w[i]) w[i] = blk[i];
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (r = 0; r < ROUND_CNT; r++) begin
        // expand the schedule in place over a 16-word window
        if (r >= 16)
          w[r % 16] = rol(w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16], 1);
        case (r / 20)
          0: f = (b & c) | (~b & d);
          2: f = (b & c) | (b & d) | (c & d);
          default: f = b ^ c ^ d;
        endcase
        t = rol(a, 5) + f + e + RC[r / 20] + w[r % 16];
        e = d;
        d = c;
        c = rol(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void place_byte(int unsigned pos, logic [7:0] val);
      int unsigned sh;
      sh = (3 - pos % 4) * 8;
      if (pos % 4 == 0)
        blk[pos / 4] = {24'h0, val} << sh;
      else
        blk[pos / 4] |= {24'h0, val} << sh;
    endfunction

    function void take_item(logic [7:0] data, logic has_byte, logic last);
      int unsigned  pos;
      int           i;
      logic [63:0]  bit_len;
      digest_beat_t beat;
      if (has_byte) begin
        pos = msg_bytes[5:0];
        place_byte(pos, data);
        msg_bytes = msg_bytes + 1'b1;
        if (pos == BLOCK_LEN - 1)
          absorb_block();
      end
      if (!last)
        return;
      pos = msg_bytes[5:0];
      place_byte(pos, PAD_MARK);
      for (i = pos / 4 + 1; i < 16; i++)
        blk[i] = '0;
      // no room left for the length: spill into one more block
      if (pos >= BLOCK_LEN - 8) begin
        absorb_block();
        foreach (blk[j]) blk[j] = '0;
      end
      bit_len = {msg_bytes, 3'b000};
      blk[14] = bit_len[63:32];
      blk[15] = bit_len[31:0];
      absorb_block();
      for (i = 0; i < WORDS_OUT; i++) begin
        beat = '{chain[i], 3'(i), i == LAST_IDX};
        digest_q = {digest_q, beat};
      end
      restart();
    endfunction

    task report(string what);
      $display("digest check: %s", what);
      mismatches++;
    endtask

    task check_word(logic [31:0] word, logic [2:0] index, logic last_word);
      digest_beat_t want;
      if (digest_q.size() == 0) begin
        report($sformatf("unexpected beat word %h index %0d", word, index));
        return;
      end
      want = digest_q.pop_front();
      if (word !== want.word)
        report($sformatf("word %0d: got %h, want %h", want.index, word, want.word));
      if (index !== want.index)
        report($sformatf("index: got %0d, want %0d", index, want.index));
      if (last_word !== want.final_word)
        report($sformatf("last_word on index %0d: got %b, want %b",
                         want.index, last_word, want.final_word));
    endtask

    function int pending();
      return digest_q.size();
    endfunction
  endclass

endpackage

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import digest_check_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 250;
  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 400;
  localparam int ITEM_TARGET  = 270;
  localparam int CALM_AFTER   = 240;
  localparam int MIN_MESSAGES = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data = 8'h00;
  logic        in_has_byte = 1'b0;
  logic        in_last = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  digest_scoreboard sb;
  bit  calm = 1'b0;
  bit  squeeze_pending = 1'b0;
  int  items_sent = 0;
  int  quiet_cycles = 0;

  int unsigned wrap_lens [4] = '{55, 56, 63, 64};
  int unsigned long_lens [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  always #5 clk = ~clk;

  sha1_hash dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .in_has_byte     (in_has_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.take_item(in_data, in_has_byte, in_last);
      if (out_valid && !out_stall)
        sb.check_word(out_digest_word, out_word_index, out_last_word);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall bursts, one long hold-off, none at the end.
  initial begin
    int n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (squeeze_pending && out_valid) begin
        squeeze_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm || $urandom_range(0, 2) != 0) begin
        n = calm ? 1 : $urandom_range(1, 24);
        out_stall <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Hold the beat until it is taken; returns right after the accepting edge.
  task automatic send_beat(logic [7:0] d, logic hb, logic lst);
    in_valid    <= 1'b1;
    in_data     <= d;
    in_has_byte <= hb;
    in_last     <= lst;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause(bit steady);
    int n;
    if (!calm && !steady && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_message(int unsigned len, bit end_on_byte);
    int unsigned j;
    bit          steady;
    steady = ($urandom_range(0, 3) == 0);
    for (j = 0; j < len; j++) begin
      // drop in an ignored beat now and then
      if ($urandom_range(0, 19) == 0)
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      pause(steady);
      send_beat(8'($urandom_range(0, 255)), 1'b1, end_on_byte && j == len - 1);
      items_sent++;
      if (items_sent >= CALM_AFTER)
        calm = 1'b1;
    end
    if (!end_on_byte) begin
      pause(steady);
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      items_sent++;
    end
  endtask

  initial begin
    int          msgs;
    int unsigned len;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message
    send_beat(8'h5a, 1'b0, 1'b1);
    // "abc", finished on the last byte
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    // ignored beat between messages
    send_beat(8'hff, 1'b0, 1'b0);
    // extremes, an ignored beat inside, closed by a byteless last
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'hff, 1'b0, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_message(10, 1'b0);

    squeeze_pending = 1'b1;
    items_sent = 0;
    msgs = 0;
    while (items_sent < ITEM_TARGET || msgs < MIN_MESSAGES) begin
      if (msgs < 4)
        len = wrap_lens[msgs];
      else if ($urandom_range(0, 9) < 7)
        len = $urandom_range(0, 16);
      else
        len = long_lens[$urandom_range(0, 7)];
      send_message(len, len != 0 && $urandom_range(0, 1) == 1);
      msgs++;
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
